@@ rtl/core/rbdeq_pkg.sv @@
// Package with the types, constants and codes shared by the deque cell row and its top level.
package rbdeq_pkg;

  // Capacity of the queue and the width of the word counter.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;

  // Operation codes carried in the func field of an item.
  typedef enum logic [2:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_NONE       = 3'd4
  } func_e;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY      = 2'd2
  } status_e;

  // The operation that every cell of the row performs at a clock edge.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHR,
    OP_SHL,
    OP_APPEND,
    OP_TRIM
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

  // Input item.
  typedef struct packed {
    logic [2:0]               func;
    logic signed [WORD_W-1:0] push_value;
  } cmd_t;

  // Result item.
  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic [1:0]               status;
    logic [4:0]               count_after;
    logic signed [WORD_W-1:0] first_value;
    logic signed [WORD_W-1:0] last_value;
  } res_t;

endpackage

@@ rtl/core/rbdeq_cell.sv @@
// One storage cell of the deque row: holds a word and its occupied flag.
module rbdeq_cell
  import rbdeq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [WORD_W-1:0] push_value_i,
  input  logic signed [WORD_W-1:0] left_data_i,
  input  logic                     left_valid_i,
  input  logic signed [WORD_W-1:0] right_data_i,
  input  logic                     right_valid_i,
  output logic signed [WORD_W-1:0] data_o,
  output logic                     valid_o,
  output logic                     last_o
);

  logic signed [WORD_W-1:0] data_q, data_d;
  logic                     valid_q, valid_d;

  // This cell holds the back word when it is occupied and its right neighbour is not.
  assign last_o  = valid_q && !right_valid_i;
  assign data_o  = data_q;
  assign valid_o = valid_q;

  // Next contents: take from a neighbour on a shift, fill or free at the back end.
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      OP_SHR: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      OP_SHL: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      OP_APPEND: begin
        if (!valid_q && left_valid_i) begin
          data_d  = push_value_i;
          valid_d = 1'b1;
        end
      end
      OP_TRIM: begin
        if (last_o) begin
          valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // The occupied flag is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // The word itself needs no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

@@ rtl/core/ring_buffer_double_ended_queue.sv @@
// Top level of the double-ended queue built as a row of shifting cells.
//
// A command item is taken at every rising edge with start_i high; busy_o never
// rises, so one item can follow another in every cycle. Its result appears on
// result_o in the very next cycle, marked by done_o for exactly that one cycle,
// and must be captured then. The front of the queue always sits in the first
// cell: a push or pop at the front shifts the whole cell row by one place, and a
// push or pop at the back fills or frees the cell at the boundary of the occupied
// run. The count, front and back words in a result are those after the item's
// operation; both words read zero when empty.
module ring_buffer_double_ended_queue
  import rbdeq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  output logic busy_o,
  output logic done_o,
  output res_t result_o
);

  logic [DEPTH-1:0]               valid_vec;
  logic [DEPTH-1:0]               last_vec;
  logic signed [WORD_W-1:0]       data_vec [DEPTH];
  logic signed [WORD_W-1:0]       back_word;
  cell_ctrl_t                     ctrl;
  logic [CNT_W-1:0]               count_q, count_d;
  logic signed [WORD_W-1:0]       popped_q, popped_d;
  status_e                        status_q, status_d;
  logic                           done_q;
  logic                           accept;
  logic                           full;
  logic                           empty;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);

  // Row of cells; the outer ends see a push word on the left and nothing on the right.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_data, right_data;
    logic                     left_valid, right_valid;
    if (i == 0) begin : g_first
      assign left_data  = cmd_i.push_value;
      assign left_valid = 1'b1;
    end else begin : g_inner_l
      assign left_data  = data_vec[i-1];
      assign left_valid = valid_vec[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_r
      assign right_data  = data_vec[i+1];
      assign right_valid = valid_vec[i+1];
    end
    rbdeq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .push_value_i (cmd_i.push_value),
      .left_data_i  (left_data),
      .left_valid_i (left_valid),
      .right_data_i (right_data),
      .right_valid_i(right_valid),
      .data_o       (data_vec[i]),
      .valid_o      (valid_vec[i]),
      .last_o       (last_vec[i])
    );
  end

  // Back word: only the cell at the end of the occupied run contributes.
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | (last_vec[i] ? data_vec[i] : '0);
    end
  end

  // Decode the item into a row operation, the next count, a status and the popped word.
  always_comb begin
    ctrl.op  = OP_HOLD;
    count_d  = count_q;
    popped_d = '0;
    status_d = ST_DONE;
    if (accept) begin
      case (cmd_i.func)
        FUNC_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.op = OP_SHR;
            count_d = count_q + 1'b1;
          end
        end
        FUNC_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.op = OP_APPEND;
            count_d = count_q + 1'b1;
          end
        end
        FUNC_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.op  = OP_SHL;
            count_d  = count_q - 1'b1;
            popped_d = data_vec[0];
          end
        end
        FUNC_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.op  = OP_TRIM;
            count_d  = count_q - 1'b1;
            popped_d = back_word;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Count and result strobe are control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
    status_q <= status_d;
  end

  // The result reads the row as it stands after the item's operation.
  assign done_o                = done_q;
  assign result_o.popped_value = popped_q;
  assign result_o.status       = status_q;
  assign result_o.count_after  = 5'(count_q);
  assign result_o.first_value  = valid_vec[0] ? data_vec[0] : '0;
  assign result_o.last_value   = back_word;

  // The number of occupied cells must equal the word count.
  a_run_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("occupied cells disagree with the word count");

  a_single_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(last_vec) && ((last_vec == '0) == empty))
    else $error("back end of the occupied run is not unique");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted item produced no result");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.status == ST_FULL) |-> full && $stable(count_q))
    else $error("rejected push changed the queue");

  a_empty_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.status == ST_EMPTY) |-> empty && (result_o.popped_value == '0))
    else $error("rejected pop returned data or queue not empty");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the ring buffer double-ended queue: directed and random items.
module tb_top
  import rbdeq_pkg::*;
;

  // Spare operation codes, which the block must treat as no operation.
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  localparam int RANDOM_OPS   = 2000;
  localparam int SEGMENT_LEN  = 60;
  localparam int SETTLE_TICKS = 8;
  localparam int STALL_LIMIT  = 1000;
  localparam int REPORT_MAX   = 10;

  // One entry of the stimulus backlog: the command, the idle cycles before it,
  // and whether the sender must wait for every outstanding result first.
  typedef struct {
    cmd_t cmd;
    int   gap;
    bit   drain;
  } stim_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  cmd_t cmd_i   = '0;
  logic busy_o;
  logic done_o;
  res_t result_o;

  stim_t cmd_backlog[$];
  res_t  due_results[$];

  // Shadow copy of the queue contents, kept in step with accepted items.
  logic signed [WORD_W-1:0] shadow_mem [DEPTH];
  int shadow_head = 0;
  int shadow_fill = 0;

  int in_flight    = 0;
  int wait_left    = 0;
  bit front_loaded = 1'b0;
  int accepted_n   = 0;
  int results_n    = 0;
  int fault_n      = 0;
  int idle_run     = 0;
  int refused_full = 0;
  int refused_dry  = 0;
  int peak_fill    = 0;

  ring_buffer_double_ended_queue DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Free-running clock with a period of ten units.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one command to the shadow queue and returns the result it should give.
  function automatic res_t deque_apply(cmd_t c);
    res_t r;
    r = '0;
    r.status = ST_DONE;
    case (c.func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
          refused_full++;
        end else if (c.func == FUNC_PUSH_FRONT) begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_mem[shadow_head] = c.push_value;
          shadow_fill++;
        end else begin
          shadow_mem[(shadow_head + shadow_fill) % DEPTH] = c.push_value;
          shadow_fill++;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
          refused_dry++;
        end else if (c.func == FUNC_POP_FRONT) begin
          r.popped_value = shadow_mem[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_fill--;
        end else begin
          r.popped_value = shadow_mem[(shadow_head + shadow_fill - 1) % DEPTH];
          shadow_fill--;
        end
      end
      default: ;
    endcase
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    r.count_after = $bits(r.count_after)'(shadow_fill);
    if (shadow_fill != 0) begin
      r.first_value = shadow_mem[shadow_head];
      r.last_value  = shadow_mem[(shadow_head + shadow_fill - 1) % DEPTH];
    end
    return r;
  endfunction

  // Words are mostly random, with the extremes and zero mixed in.
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(WORD_W-1){1'b1}}};
      1:       return {1'b1, {(WORD_W-1){1'b0}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Idle gaps are mostly absent or short, now and then long.
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_cmd(logic [2:0] f, logic signed [WORD_W-1:0] v, int gap,
                                    bit drain);
    stim_t s;
    s.cmd.func       = f;
    s.cmd.push_value = v;
    s.gap            = gap;
    s.drain          = drain;
    cmd_backlog.push_back(s);
  endfunction

  function automatic void note_fault(string what);
    fault_n++;
    if (fault_n <= REPORT_MAX) $display("mismatch at result %0d: %s", results_n, what);
  endfunction

  // Sender: issues backlog items, honours gaps, drains and busy, and predicts each accepted item.
  always @(posedge clk_i) begin
    bit   took;
    bit   go;
    cmd_t nxt;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      took = start_i && !busy_o;
      go   = 1'b0;
      nxt  = {3'($urandom_range(0, 7)), WORD_W'($urandom)};
      if (took) begin
        due_results.push_back(deque_apply(cmd_i));
        void'(cmd_backlog.pop_front());
        front_loaded = 1'b0;
        accepted_n++;
      end
      in_flight = in_flight + int'(took) - int'(done_o === 1'b1);
      if (start_i && !took) begin
        go  = 1'b1;
        nxt = cmd_i;
      end else if (cmd_backlog.size() != 0) begin
        if (!front_loaded) begin
          wait_left    = cmd_backlog[0].gap;
          front_loaded = 1'b1;
        end
        if (wait_left > 0) begin
          wait_left--;
        end else if (!(cmd_backlog[0].drain && in_flight != 0)) begin
          go  = 1'b1;
          nxt = cmd_backlog[0].cmd;
        end
      end
      start_i <= go;
      cmd_i   <= nxt;
    end
  end

  // Receiver: checks every strobed result against the oldest prediction, and watches for stalls.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        results_n++;
        if (due_results.size() == 0) begin
          note_fault("result strobed with no item outstanding");
        end else begin
          want = due_results.pop_front();
          if (result_o.popped_value !== want.popped_value)
            note_fault($sformatf("popped_value exp %0d got %0d",
                                 want.popped_value, result_o.popped_value));
          if (result_o.status !== want.status)
            note_fault($sformatf("status exp %0d got %0d", want.status, result_o.status));
          if (result_o.count_after !== want.count_after)
            note_fault($sformatf("count_after exp %0d got %0d",
                                 want.count_after, result_o.count_after));
          if (result_o.first_value !== want.first_value)
            note_fault($sformatf("first_value exp %0d got %0d",
                                 want.first_value, result_o.first_value));
          if (result_o.last_value !== want.last_value)
            note_fault($sformatf("last_value exp %0d got %0d",
                                 want.last_value, result_o.last_value));
        end
      end
      if ((start_i && !busy_o) || done_o === 1'b1) idle_run = 0;
      else idle_run++;
      if (idle_run >= STALL_LIMIT) begin
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int               real_ops;
    int               seg;
    int               push_bias;
    bit               quiet;
    logic [2:0]       f;
    logic signed [WORD_W-1:0] v;

    // Directed part: pops on an empty queue, every idle code, then filling to capacity
    // with extreme words at both ends, and pushes refused when full.
    queue_cmd(FUNC_POP_FRONT, pick_word(), pick_gap(1'b0), 1'b0);
    queue_cmd(FUNC_POP_BACK,  pick_word(), pick_gap(1'b0), 1'b0);
    queue_cmd(FUNC_NONE,      pick_word(), pick_gap(1'b0), 1'b0);
    for (int k = int'(FUNC_SPARE_LO); k <= int'(FUNC_SPARE_HI); k++)
      queue_cmd(3'(k), pick_word(), pick_gap(1'b0), 1'b0);
    queue_cmd(FUNC_PUSH_FRONT, {1'b0, {(WORD_W-1){1'b1}}}, 0, 1'b0);
    queue_cmd(FUNC_PUSH_BACK,  {1'b1, {(WORD_W-1){1'b0}}}, 0, 1'b0);
    queue_cmd(FUNC_PUSH_FRONT, '0, 0, 1'b0);
    queue_cmd(FUNC_PUSH_BACK,  '1, 0, 1'b0);
    for (int k = 4; k < DEPTH; k++)
      queue_cmd((k % 2) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, $urandom, pick_gap(1'b0), 1'b0);
    queue_cmd(FUNC_PUSH_FRONT, pick_word(), pick_gap(1'b0), 1'b0);
    queue_cmd(FUNC_PUSH_BACK,  pick_word(), pick_gap(1'b0), 1'b0);

    // Random part in segments, each with its own push bias, most leaning towards pushes or
    // pops so that the occupancy sweeps between empty and full; some segments run without gaps.
    real_ops = 0;
    seg      = 0;
    while (real_ops < RANDOM_OPS) begin
      push_bias = $urandom_range(0, 4) * 20 + 10;
      quiet     = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < SEGMENT_LEN; k++) begin
        v = pick_word();
        if ($urandom_range(0, 99) < 5) begin
          f = 3'($urandom_range(int'(FUNC_NONE), int'(FUNC_SPARE_HI)));
        end else begin
          if ($urandom_range(0, 99) < push_bias)
            f = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
          else
            f = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
          real_ops++;
        end
        queue_cmd(f, v, pick_gap(quiet), (k == 0) && (seg % 3 == 0));
      end
      seg++;
    end

    // Hold reset, then release it away from the clock edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || in_flight != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
    while (due_results.size() != 0) begin
      void'(due_results.pop_front());
      note_fault("expected result never arrived");
    end

    $display("%0d items accepted, %0d results checked, peak occupancy %0d of %0d",
             accepted_n, results_n, peak_fill, DEPTH);
    $display("%0d pushes refused on a full queue, %0d pops refused on an empty one",
             refused_full, refused_dry);
    if (fault_n == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches in total", fault_n);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
